// File: rtl/mrmt_pkg.sv
// Shared types, constants and fixed-point helpers of the midpoint triangulator.
// No dependencies; used by the top level of the block.
package mrmt_pkg;

    localparam int IFRAC      = 40;
    localparam int POSE_WORDS = 12;
    localparam int IN_DATA_W  = 88;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 96;
    localparam int OUT_USER_W = 3;
    localparam int THR_W      = 31;
    localparam int CFG_AW     = 1;

    typedef logic signed [63:0] t_fx;

    localparam t_fx         S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam t_fx         S64_MIN = 64'sh8000_0000_0000_0000;
    localparam t_fx         DET_MIN = 64'sd1099512;
    localparam t_fx         ONE40   = 64'sd1 <<< IFRAC;
    localparam logic [63:0] CAP32   = 64'h0000_0000_7FFF_FFFF;

    localparam logic OP_POSE = 1'b0;
    localparam logic OP_OBS  = 1'b1;

    localparam logic [CFG_AW-1:0] REG_THRESHOLD = 1'b0;
    localparam logic [CFG_AW-1:0] REG_CHECK_EN  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DEGEN = 2'd1;
    localparam logic [1:0] ST_FAR   = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE, S_RD, S_RD_USE, S_ROT_ACC, S_NORM_TOP, S_NORM_SH,
        S_SS_GO, S_SS_ACC, S_DIR_GO, S_DIR_DONE, S_NM_GO, S_NM_DONE,
        S_NS_UPD, S_RHS_GO, S_RHS_DONE, S_STORE, S_ADJ_GO, S_ADJ_DONE,
        S_DET_GO, S_DET_DONE, S_DET_CHK, S_SOL_GO, S_SOL_DONE, S_SOL_DIVGO,
        S_SOL_QUO, S_THR_GO, S_THR_DONE, S_DST_DIFF, S_DOT_GO, S_DOT_DONE,
        S_PRP_GO, S_PRP_MID, S_PRP_DONE, S_DST_CHK, S_OUT,
        S_MUL, S_DIV, S_SQRT
    } t_state;

    // Entries of the symmetric normal matrix: xx, xy, xz, yy, yz, zz.
    localparam logic [1:0] NM_I [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam logic [1:0] NM_J [6] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

    // Adjugate products, taken in pairs: each cofactor is first minus second.
    localparam logic [2:0] ADJ_A [12] = '{3'd3, 3'd4, 3'd2, 3'd1, 3'd1, 3'd2,
                                          3'd0, 3'd2, 3'd1, 3'd0, 3'd0, 3'd1};
    localparam logic [2:0] ADJ_B [12] = '{3'd5, 3'd4, 3'd4, 3'd5, 3'd4, 3'd3,
                                          3'd5, 3'd2, 3'd2, 3'd4, 3'd3, 3'd1};

    // Pose word order: rotation row-major, then translation x, y, z.
    localparam logic [1:0] POSE_ROW [12] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1,
                                             2'd2, 2'd2, 2'd2, 2'd0, 2'd1, 2'd2};
    localparam logic [1:0] POSE_COL [12] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
                                             2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd0};

    function automatic logic [2:0] sym_idx(input logic [1:0] i, input logic [1:0] j);
        logic [2:0] r;
        case ({i, j})
            4'b0000: r = 3'd0;
            4'b0001, 4'b0100: r = 3'd1;
            4'b0010, 4'b1000: r = 3'd2;
            4'b0101: r = 3'd3;
            4'b0110, 4'b1001: r = 3'd4;
            4'b1010: r = 3'd5;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic t_fx sat_add(input t_fx a, input t_fx b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

    function automatic t_fx sat_sub(input t_fx a, input t_fx b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic [63:0] mag64(input t_fx a);
        return a[63] ? (~a + 64'd1) : a;
    endfunction

    function automatic t_fx from_wide(input logic [127:0] w, input logic neg,
                                      input logic [63:0] cap);
        logic [63:0] m;
        m = (w > {64'd0, cap}) ? cap : w[63:0];
        return neg ? (~m + 64'd1) : m;
    endfunction

    function automatic t_fx qmul_res(input logic [127:0] prod, input logic neg);
        return from_wide(prod >> IFRAC, neg, S64_MAX);
    endfunction

endpackage

// File: rtl/mrmt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the per-camera pose table.
module mrmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 48,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/multi_ray_midpoint_triangulator.sv
// Multi-view midpoint ray triangulator, top level.
// An observation spends most of its time in the shared divider, run three times
// for the ray direction. The last observation adds the solve, plus a distance pass
// per view when the distance check is enabled. One item is in work at a time;
// ready is low meanwhile.
// Reset (synchronous, active low) clears control and sums; the pose table has no reset.
module multi_ray_midpoint_triangulator #(
    parameter int MAX_CAMERAS = 4,
    parameter int FRAC_BITS   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mrmt_pkg::CFG_AW-1:0]       i_cfg_addr,
    input  logic [mrmt_pkg::THR_W-1:0]        i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // camera[1:0], pose_index[5:2], pose_value[37:6], obs_x[61:38], obs_y[85:62]
    input  logic [mrmt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // opcode[0]
    input  logic [mrmt_pkg::IN_USER_W-1:0]    s_axis_tuser,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // point_x[31:0], point_y[63:32], point_z[95:64]
    output logic [mrmt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // point_valid[0], status[2:1]
    output logic [mrmt_pkg::OUT_USER_W-1:0]   m_axis_tuser
);
    import mrmt_pkg::*;

    localparam int VW       = $clog2(MAX_CAMERAS + 1);
    localparam int VIW      = $clog2(MAX_CAMERAS);
    localparam int PDEPTH   = MAX_CAMERAS * POSE_WORDS;
    localparam int PAW      = $clog2(PDEPTH);
    localparam int SCALE_SH = IFRAC - FRAC_BITS;
    localparam t_fx ONE_IN  = 64'sd1 <<< FRAC_BITS;

    // Input fields.
    logic              in_op;
    logic [1:0]        in_cam;
    logic [3:0]        in_pidx;
    logic [31:0]       in_pval;
    logic signed [23:0] in_x, in_y;
    logic              in_cam_ok;
    logic              in_acc;

    assign in_op   = s_axis_tuser[0];
    assign in_cam  = s_axis_tdata[1:0];
    assign in_pidx = s_axis_tdata[5:2];
    assign in_pval = s_axis_tdata[37:6];
    assign in_x    = s_axis_tdata[61:38];
    assign in_y    = s_axis_tdata[85:62];
    assign in_cam_ok = (int'(in_cam) < MAX_CAMERAS);

    t_state r_state, n_state, r_ret, n_ret;
    logic [3:0]  r_k, n_k;
    logic [1:0]  r_j, n_j;
    logic [6:0]  r_uc, n_uc;
    logic [VW-1:0] r_v, n_v, r_views, n_views;
    logic        r_last, n_last;
    logic [1:0]  r_status, n_status;
    logic        r_ovalid, n_ovalid;
    logic [THR_W-1:0] r_thr, n_thr;
    logic        r_chk, n_chk;

    logic [1:0]  r_cam, n_cam;
    logic signed [23:0] r_x, n_x, r_y, n_y;
    t_fx         r_w [3], n_w [3];
    logic [63:0] r_m [3], n_m [3];
    logic [63:0] r_top, n_top;
    t_fx         r_p [3], n_p [3];
    t_fx         r_r [3], n_r [3];
    t_fx         r_nm [6], n_nm [6];
    t_fx         r_ns [6], n_ns [6];
    t_fx         r_rhs [3], n_rhs [3];
    t_fx         r_kk [6], n_kk [6];
    t_fx         r_acc, n_acc, r_tmp, n_tmp, r_det, n_det;
    t_fx         r_x40 [3], n_x40 [3];
    logic [31:0] r_xo [3], n_xo [3];
    t_fx         r_diff [3], n_diff [3];
    logic [127:0] r_num, n_num, r_t2, n_t2, r_d2, n_d2;
    logic [63:0] r_s, n_s, r_sres, n_sres, r_sbit, n_sbit;
    t_fx         r_org [MAX_CAMERAS][3], n_org [MAX_CAMERAS][3];
    t_fx         r_dir [MAX_CAMERAS][3], n_dir [MAX_CAMERAS][3];
    logic [31:0] r_ox [3], n_ox [3];
    logic [1:0]  r_ost, n_ost;

    // Shared multiplier and divider operands.
    logic [63:0]  r_ma, n_ma, r_mb, n_mb;
    logic         r_mneg, n_mneg;
    logic [127:0] r_prod, n_prod;
    logic [127:0] r_dn, n_dn, r_dq, n_dq;
    logic [63:0]  r_drem, n_drem, r_dd, n_dd;
    logic         r_qneg, n_qneg;

    // Pose table.
    logic           ram_we;
    logic [PAW-1:0] ram_waddr, ram_raddr;
    logic [31:0]    ram_rdata;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign ram_we = in_acc && (in_op == OP_POSE) && in_cam_ok && (in_pidx < 4'(POSE_WORDS));
    assign ram_waddr = PAW'(in_cam) * PAW'(POSE_WORDS) + PAW'(in_pidx);
    assign ram_raddr = PAW'(r_cam) * PAW'(POSE_WORDS) + PAW'(r_k);

    mrmt_ram #(.WIDTH(32), .DEPTH(PDEPTH)) u_pose (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (in_pval),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        logic        ld_go, ld_signed;
        t_fx         lda, ldb;
        t_fx         pv, vj, q, diag, a2;
        logic [63:0] t01, sq_sum, pm;
        logic [127:0] t, pp, num2;
        logic [1:0]  sh;
        logic [64:0] rem2;
        logic        qb;
        logic [VIW-1:0] vi;

        ld_go = 1'b0; ld_signed = 1'b1; lda = '0; ldb = '0;
        pv = t_fx'($signed(ram_rdata));
        vj = ONE_IN;
        q = qmul_res(r_prod, r_mneg);
        diag = '0; a2 = '0; t01 = '0; sq_sum = '0; pm = '0;
        t = '0; pp = '0; num2 = '0; sh = '0; rem2 = '0; qb = 1'b0;
        vi = r_v[VIW-1:0];

        n_state = r_state; n_ret = r_ret; n_k = r_k; n_j = r_j; n_uc = r_uc;
        n_v = r_v; n_views = r_views; n_last = r_last; n_status = r_status;
        n_ovalid = r_ovalid; n_thr = r_thr; n_chk = r_chk;
        n_cam = r_cam; n_x = r_x; n_y = r_y; n_w = r_w; n_m = r_m; n_top = r_top;
        n_p = r_p; n_r = r_r; n_nm = r_nm; n_ns = r_ns; n_rhs = r_rhs; n_kk = r_kk;
        n_acc = r_acc; n_tmp = r_tmp; n_det = r_det; n_x40 = r_x40; n_xo = r_xo;
        n_diff = r_diff; n_num = r_num; n_t2 = r_t2; n_d2 = r_d2;
        n_s = r_s; n_sres = r_sres; n_sbit = r_sbit; n_org = r_org; n_dir = r_dir;
        n_ox = r_ox; n_ost = r_ost;
        n_ma = r_ma; n_mb = r_mb; n_mneg = r_mneg; n_prod = r_prod;
        n_dn = r_dn; n_dq = r_dq; n_drem = r_drem; n_dd = r_dd; n_qneg = r_qneg;

        if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_THRESHOLD: n_thr = i_cfg_wdata;
                REG_CHECK_EN:  n_chk = i_cfg_wdata[0];
                default:       n_chk = r_chk;
            endcase
        end

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid && in_op == OP_OBS) begin
                    n_cam = in_cam; n_x = in_x; n_y = in_y; n_last = s_axis_tlast;
                    n_k = '0;
                    if (in_cam_ok && r_views < VW'(MAX_CAMERAS)) begin
                        n_w = '{default: '0};
                        n_state = S_RD;
                    end else if (s_axis_tlast) begin
                        n_state = S_ADJ_GO;
                    end
                end
            end
            S_RD: n_state = S_RD_USE;
            S_RD_USE: begin
                if (r_k < 4'd9) begin
                    case (POSE_COL[r_k])
                        2'd0:    vj = t_fx'(r_x);
                        2'd1:    vj = t_fx'(r_y);
                        default: vj = ONE_IN;
                    endcase
                    lda = pv; ldb = vj; ld_go = 1'b1; n_ret = S_ROT_ACC;
                end else begin
                    n_p[POSE_ROW[r_k]] = pv <<< SCALE_SH;
                    n_k = r_k + 4'd1;
                    n_state = (r_k == 4'd11) ? S_NORM_TOP : S_RD;
                end
            end
            S_ROT_ACC: begin
                t = r_mneg ? (~r_prod + 128'd1) : r_prod;
                n_w[POSE_ROW[r_k]] = r_w[POSE_ROW[r_k]] + t_fx'(t[63:0]);
                n_k = r_k + 4'd1;
                n_state = S_RD;
            end
            S_NORM_TOP: begin
                for (int i = 0; i < 3; i++) begin
                    n_m[i] = mag64(r_w[i]);
                end
                t01 = (n_m[0] > n_m[1]) ? n_m[0] : n_m[1];
                n_top = (t01 > n_m[2]) ? t01 : n_m[2];
                if (n_top == 64'd0) begin
                    n_r = '{default: '0};
                    n_k = '0;
                    n_state = S_NM_GO;
                end else begin
                    n_state = S_NORM_SH;
                end
            end
            S_NORM_SH: begin
                // Bring the largest magnitude into [2^30, 2^31), one bit a cycle.
                if (r_top[63:31] != '0) begin
                    n_top = r_top >> 1;
                    for (int i = 0; i < 3; i++) n_m[i] = r_m[i] >> 1;
                end else if (!r_top[30]) begin
                    n_top = r_top << 1;
                    for (int i = 0; i < 3; i++) n_m[i] = r_m[i] << 1;
                end else begin
                    n_k = '0; n_s = '0;
                    n_state = S_SS_GO;
                end
            end
            S_SS_GO: begin
                ld_signed = 1'b0; lda = r_m[r_k[1:0]]; ldb = r_m[r_k[1:0]];
                ld_go = 1'b1; n_ret = S_SS_ACC;
            end
            S_SS_ACC: begin
                sq_sum = r_s + r_prod[63:0];
                n_s = sq_sum;
                n_k = r_k + 4'd1;
                if (r_k == 4'd2) begin
                    n_sres = '0; n_sbit = 64'd1 << 62; n_uc = '0; n_k = '0;
                    n_ret = S_DIR_GO; n_state = S_SQRT;
                end else begin
                    n_state = S_SS_GO;
                end
            end
            S_SQRT: begin
                sq_sum = r_sres + r_sbit;
                if (r_s >= sq_sum) begin
                    n_s = r_s - sq_sum;
                    n_sres = (r_sres >> 1) + r_sbit;
                end else begin
                    n_sres = r_sres >> 1;
                end
                n_sbit = r_sbit >> 2;
                n_uc = r_uc + 7'd1;
                if (r_uc == 7'd31) n_state = r_ret;
            end
            S_DIR_GO: begin
                n_dn = 128'(r_m[r_k[1:0]]) << IFRAC;
                n_dd = r_sres; n_drem = '0; n_dq = '0; n_uc = '0;
                n_qneg = r_w[r_k[1:0]][63];
                n_ret = S_DIR_DONE; n_state = S_DIV;
            end
            S_DIR_DONE: begin
                n_r[r_k[1:0]] = from_wide(r_dq, r_qneg, S64_MAX);
                n_k = r_k + 4'd1;
                if (r_k == 4'd2) begin
                    n_k = '0; n_state = S_NM_GO;
                end else begin
                    n_state = S_DIR_GO;
                end
            end
            S_NM_GO: begin
                lda = r_r[NM_I[r_k[2:0]]]; ldb = r_r[NM_J[r_k[2:0]]];
                ld_go = 1'b1; n_ret = S_NM_DONE;
            end
            S_NM_DONE: begin
                diag = (NM_I[r_k[2:0]] == NM_J[r_k[2:0]]) ? ONE40 : '0;
                n_nm[r_k[2:0]] = sat_sub(diag, q);
                n_k = r_k + 4'd1;
                n_state = (r_k == 4'd5) ? S_NS_UPD : S_NM_GO;
            end
            S_NS_UPD: begin
                for (int i = 0; i < 6; i++) n_ns[i] = sat_add(r_ns[i], r_nm[i]);
                n_k = '0; n_j = '0; n_acc = '0;
                n_state = S_RHS_GO;
            end
            S_RHS_GO: begin
                lda = r_nm[sym_idx(r_k[1:0], r_j)]; ldb = r_p[r_j];
                ld_go = 1'b1; n_ret = S_RHS_DONE;
            end
            S_RHS_DONE: begin
                a2 = sat_add(r_acc, q);
                if (r_j == 2'd2) begin
                    n_rhs[r_k[1:0]] = sat_add(r_rhs[r_k[1:0]], a2);
                    n_acc = '0; n_j = '0; n_k = r_k + 4'd1;
                    n_state = (r_k == 4'd2) ? S_STORE : S_RHS_GO;
                end else begin
                    n_acc = a2; n_j = r_j + 2'd1;
                    n_state = S_RHS_GO;
                end
            end
            S_STORE: begin
                for (int i = 0; i < 3; i++) begin
                    n_org[r_views[VIW-1:0]][i] = r_p[i];
                    n_dir[r_views[VIW-1:0]][i] = r_r[i];
                end
                n_views = r_views + VW'(1);
                n_k = '0;
                n_state = r_last ? S_ADJ_GO : S_IDLE;
            end
            S_ADJ_GO: begin
                lda = r_ns[ADJ_A[r_k]]; ldb = r_ns[ADJ_B[r_k]];
                ld_go = 1'b1; n_ret = S_ADJ_DONE;
            end
            S_ADJ_DONE: begin
                if (!r_k[0]) n_tmp = q;
                else n_kk[r_k[3:1]] = sat_sub(r_tmp, q);
                n_k = r_k + 4'd1;
                if (r_k == 4'd11) begin
                    n_k = '0; n_acc = '0; n_state = S_DET_GO;
                end else begin
                    n_state = S_ADJ_GO;
                end
            end
            S_DET_GO: begin
                lda = r_ns[r_k[2:0]]; ldb = r_kk[r_k[2:0]];
                ld_go = 1'b1; n_ret = S_DET_DONE;
            end
            S_DET_DONE: begin
                n_acc = sat_add(r_acc, q);
                n_k = r_k + 4'd1;
                n_state = (r_k == 4'd2) ? S_DET_CHK : S_DET_GO;
            end
            S_DET_CHK: begin
                if (r_acc < DET_MIN) begin
                    n_status = ST_DEGEN; n_state = S_OUT;
                end else begin
                    n_status = ST_OK; n_det = r_acc;
                    n_k = '0; n_j = '0; n_num = '0;
                    n_state = S_SOL_GO;
                end
            end
            S_SOL_GO: begin
                lda = r_kk[sym_idx(r_k[1:0], r_j)]; ldb = r_rhs[r_j];
                ld_go = 1'b1; n_ret = S_SOL_DONE;
            end
            S_SOL_DONE: begin
                t = r_mneg ? (~r_prod + 128'd1) : r_prod;
                n_num = r_num + t;
                if (r_j == 2'd2) begin
                    n_state = S_SOL_DIVGO;
                end else begin
                    n_j = r_j + 2'd1; n_state = S_SOL_GO;
                end
            end
            S_SOL_DIVGO: begin
                n_qneg = r_num[127];
                num2 = r_num[127] ? (~r_num + 128'd1) : r_num;
                n_dn = num2; n_dd = r_det; n_drem = '0; n_dq = '0; n_uc = '0;
                n_ret = S_SOL_QUO; n_state = S_DIV;
            end
            S_SOL_QUO: begin
                n_x40[r_k[1:0]] = from_wide(r_dq, r_qneg, S64_MAX);
                a2 = from_wide(r_dq >> SCALE_SH, r_qneg, CAP32);
                n_xo[r_k[1:0]] = a2[31:0];
                n_num = '0; n_j = '0; n_k = r_k + 4'd1;
                if (r_k == 4'd2) n_state = r_chk ? S_THR_GO : S_OUT;
                else n_state = S_SOL_GO;
            end
            S_THR_GO: begin
                ld_signed = 1'b0;
                lda = t_fx'(64'(r_thr) << SCALE_SH); ldb = lda;
                ld_go = 1'b1; n_ret = S_THR_DONE;
            end
            S_THR_DONE: begin
                n_t2 = r_prod; n_v = '0;
                n_state = (r_views == '0) ? S_OUT : S_DST_DIFF;
            end
            S_DST_DIFF: begin
                for (int i = 0; i < 3; i++) n_diff[i] = sat_sub(r_x40[i], r_org[vi][i]);
                n_acc = '0; n_j = '0; n_d2 = '0;
                n_state = S_DOT_GO;
            end
            S_DOT_GO: begin
                lda = r_diff[r_j]; ldb = r_dir[vi][r_j];
                ld_go = 1'b1; n_ret = S_DOT_DONE;
            end
            S_DOT_DONE: begin
                n_acc = sat_add(r_acc, q);
                if (r_j == 2'd2) begin
                    n_j = '0; n_state = S_PRP_GO;
                end else begin
                    n_j = r_j + 2'd1; n_state = S_DOT_GO;
                end
            end
            S_PRP_GO: begin
                lda = r_dir[vi][r_j]; ldb = r_acc;
                ld_go = 1'b1; n_ret = S_PRP_MID;
            end
            S_PRP_MID: begin
                pm = mag64(sat_sub(r_diff[r_j], q));
                ld_signed = 1'b0; lda = t_fx'(pm); ldb = t_fx'(pm);
                ld_go = 1'b1; n_ret = S_PRP_DONE;
            end
            S_PRP_DONE: begin
                n_d2 = r_d2 + r_prod;
                if (r_j == 2'd2) begin
                    n_state = S_DST_CHK;
                end else begin
                    n_j = r_j + 2'd1; n_state = S_PRP_GO;
                end
            end
            S_DST_CHK: begin
                if (!(r_d2 < r_t2)) begin
                    n_status = ST_FAR; n_state = S_OUT;
                end else if (r_v + VW'(1) == r_views) begin
                    n_state = S_OUT;
                end else begin
                    n_v = r_v + VW'(1); n_state = S_DST_DIFF;
                end
            end
            S_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_ost = r_status;
                    for (int i = 0; i < 3; i++) begin
                        n_ox[i] = (r_status == ST_OK) ? r_xo[i] : 32'd0;
                    end
                    n_ns = '{default: '0};
                    n_rhs = '{default: '0};
                    n_views = '0;
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                // One 32x32 partial product a cycle, four for a full 64x64 product.
                pp = {64'd0, {32'd0, r_uc[0] ? r_ma[63:32] : r_ma[31:0]}
                             * {32'd0, r_uc[1] ? r_mb[63:32] : r_mb[31:0]}};
                sh = {1'b0, r_uc[0]} + {1'b0, r_uc[1]};
                case (sh)
                    2'd0:    n_prod = r_prod + pp;
                    2'd1:    n_prod = r_prod + (pp << 32);
                    default: n_prod = r_prod + (pp << 64);
                endcase
                n_uc = r_uc + 7'd1;
                if (r_uc == 7'd3) n_state = r_ret;
            end
            S_DIV: begin
                // Restoring division, one quotient bit a cycle.
                rem2 = {r_drem, r_dn[127]};
                qb = (rem2 >= {1'b0, r_dd});
                if (qb) rem2 = rem2 - {1'b0, r_dd};
                n_drem = rem2[63:0];
                n_dn = r_dn << 1;
                n_dq = {r_dq[126:0], qb};
                n_uc = r_uc + 7'd1;
                if (r_uc == 7'd127) n_state = r_ret;
            end
            default: n_state = S_IDLE;
        endcase

        if (ld_go) begin
            n_ma = ld_signed ? mag64(lda) : lda;
            n_mb = ld_signed ? mag64(ldb) : ldb;
            n_mneg = ld_signed && (lda[63] ^ ldb[63]);
            n_prod = '0; n_uc = '0;
            n_state = S_MUL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret <= S_IDLE;
            r_k <= '0;
            r_j <= '0;
            r_uc <= '0;
            r_v <= '0;
            r_views <= '0;
            r_last <= 1'b0;
            r_status <= ST_OK;
            r_ovalid <= 1'b0;
            r_thr <= THR_W'(3276800);
            r_chk <= 1'b1;
            r_ns <= '{default: '0};
            r_rhs <= '{default: '0};
        end else begin
            r_state <= n_state;
            r_ret <= n_ret;
            r_k <= n_k;
            r_j <= n_j;
            r_uc <= n_uc;
            r_v <= n_v;
            r_views <= n_views;
            r_last <= n_last;
            r_status <= n_status;
            r_ovalid <= n_ovalid;
            r_thr <= n_thr;
            r_chk <= n_chk;
            r_ns <= n_ns;
            r_rhs <= n_rhs;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cam <= n_cam; r_x <= n_x; r_y <= n_y; r_w <= n_w; r_m <= n_m; r_top <= n_top;
        r_p <= n_p; r_r <= n_r; r_nm <= n_nm; r_kk <= n_kk;
        r_acc <= n_acc; r_tmp <= n_tmp; r_det <= n_det; r_x40 <= n_x40; r_xo <= n_xo;
        r_diff <= n_diff; r_num <= n_num; r_t2 <= n_t2; r_d2 <= n_d2;
        r_s <= n_s; r_sres <= n_sres; r_sbit <= n_sbit; r_org <= n_org; r_dir <= n_dir;
        r_ox <= n_ox; r_ost <= n_ost;
        r_ma <= n_ma; r_mb <= n_mb; r_mneg <= n_mneg; r_prod <= n_prod;
        r_dn <= n_dn; r_dq <= n_dq; r_drem <= n_drem; r_dd <= n_dd; r_qneg <= n_qneg;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_ox[2], r_ox[1], r_ox[0]};
    assign m_axis_tuser  = {r_ost, (r_ost == ST_OK)};

    // A rejected point never carries coordinates.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2:1] != ST_OK |-> m_axis_tdata == '0)
        else $error("rejected point with nonzero coordinates");

    a_views_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_views <= VW'(MAX_CAMERAS))
        else $error("view count beyond camera count");

    a_sums_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && n_state == S_IDLE |=> r_views == '0 && m_axis_tvalid)
        else $error("point finished without clearing the sums");

    a_unit_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MUL || r_state == S_DIV || r_state == S_SQRT |->
        r_ret != S_MUL && r_ret != S_DIV && r_ret != S_SQRT && r_ret != S_IDLE)
        else $error("shared unit has no caller to return to");
endmodule
